@@ design/wnlf_pkg.sv @@
// Shared types and constants for the weigh notch and low-pass filter.
`timescale 1ns / 1ps

package wnlf_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int SAMPLE_W = 16;
    localparam int WORK_W = 32;
    localparam int CELL_W = 48;
    localparam int FRAC_W = 16;
    localparam int SUM_W = 24;
    localparam int PROD_W = 56;
    localparam int DIV_STEPS = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LP_EN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS  = 3'd5;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_WIDEN = 2'd1;
    localparam logic [1:0] MODE_COMB  = 2'd2;
    localparam logic [1:0] MODE_AVG   = 2'd3;

    localparam logic [1:0] MODE_RESET   = MODE_OFF;
    localparam logic [7:0] LENGTH_RESET = 8'd12;
    localparam logic [4:0] WIDEN_RESET  = 5'd5;
    localparam logic       LP_EN_RESET  = 1'b0;
    localparam logic [7:0] GAIN_RESET   = 8'd255;
    localparam logic [2:0] CELLS_RESET  = 3'd1;

    localparam logic [CELL_W-1:0] HALF_COUNT = 48'h0000_0000_8000;
    localparam logic [PROD_W:0] GAIN_ROUND = 57'h80;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_HWR,
        OP_HRD,
        OP_NCALC,
        OP_DLOAD,
        OP_DSTEP,
        OP_LPSTART,
        OP_CA,
        OP_MUL,
        OP_RND,
        OP_CD,
        OP_CG,
        OP_CH,
        OP_ROUND,
        OP_BYPASS
    } dp_op_t;

    typedef struct packed {
        logic       cfg_hit;
        logic [1:0] mode;
        logic       lp_en;
        logic       no_cells;
        logic       last_cell;
        logic       div_done;
        logic       clr_last;
    } dp_status_t;

endpackage

@@ design/wnlf_ctrl.sv @@
// Sequencer for the notch, divider and low-pass cell steps.
`timescale 1ns / 1ps

module wnlf_ctrl
    import wnlf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_HWR,
        S_HRD,
        S_NCALC,
        S_DLOAD,
        S_DIV,
        S_LPSTART,
        S_CA,
        S_M1,
        S_R1,
        S_CD,
        S_M2,
        S_R2,
        S_CG,
        S_CH,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   fire;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign fire = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        op = OP_NONE;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                op = OP_CLR;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_LOAD;
                    state_next = (status.mode != MODE_OFF) ? S_HWR : S_LPSTART;
                end
            end
            S_HWR:
            begin
                op = OP_HWR;
                state_next = (status.mode == MODE_WIDEN) ? S_LPSTART : S_HRD;
            end
            S_HRD:
            begin
                op = OP_HRD;
                state_next = S_NCALC;
            end
            S_NCALC:
            begin
                op = OP_NCALC;
                state_next = (status.mode == MODE_COMB) ? S_LPSTART : S_DLOAD;
            end
            S_DLOAD:
            begin
                op = OP_DLOAD;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                op = OP_DSTEP;
                if (status.div_done)
                    state_next = S_LPSTART;
            end
            S_LPSTART:
            begin
                op = OP_LPSTART;
                state_next = (!status.lp_en || status.no_cells) ? S_FINISH : S_CA;
            end
            S_CA:
            begin
                op = OP_CA;
                state_next = S_M1;
            end
            S_M1:
            begin
                op = OP_MUL;
                state_next = S_R1;
            end
            S_R1:
            begin
                op = OP_RND;
                state_next = S_CD;
            end
            S_CD:
            begin
                op = OP_CD;
                state_next = S_M2;
            end
            S_M2:
            begin
                op = OP_MUL;
                state_next = S_R2;
            end
            S_R2:
            begin
                op = OP_RND;
                state_next = S_CG;
            end
            S_CG:
            begin
                op = OP_CG;
                state_next = S_CH;
            end
            S_CH:
            begin
                op = OP_CH;
                state_next = status.last_cell ? S_FINISH : S_CA;
            end
            S_FINISH:
            begin
                if (fire)
                begin
                    op = status.lp_en ? OP_ROUND : OP_BYPASS;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        // a register write restarts the history sweep
        if (status.cfg_hit)
        begin
            op = OP_NONE;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
        end
    end

endmodule

@@ design/wnlf_datapath.sv @@
// Config registers, history ring, divider and low-pass cell arithmetic.
`timescale 1ns / 1ps

module wnlf_datapath
    import wnlf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 256,
    parameter int MAX_CELLS = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SAMPLE_W-1:0]   sample,
    input  dp_op_t                op,
    output dp_status_t            status,
    output logic [WORK_W-1:0]     filtered
);

    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int MW = 14;
    localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);
    localparam logic [IW-1:0] WIDX_RESET = IW'(int'(LENGTH_RESET) % HISTORY_DEPTH);
    localparam logic [3:0] MAX_N = 4'(MAX_CELLS);

    logic [1:0] mode_reg;
    logic [7:0] length_reg;
    logic [4:0] widen_reg;
    logic       lp_en_reg;
    logic [7:0] gain_reg;
    logic [2:0] cells_reg;

    logic [SAMPLE_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [SAMPLE_W-1:0] rd_reg;
    logic [IW-1:0]       widx_reg;
    logic [IW-1:0]       ridx_reg;
    logic [IW-1:0]       clr_idx_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic [SAMPLE_W-1:0] x_reg;
    logic [WORK_W-1:0]   work_reg;
    logic [WORK_W-1:0]   dvd_reg;
    logic [7:0]          rem_reg;
    logic [4:0]          dcnt_reg;

    logic [CELL_W-1:0] cell_out_reg [MAX_CELLS];
    logic [CELL_W-1:0] cell_slope_reg [MAX_CELLS];
    logic [CELL_W-1:0] w_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic [CW-1:0]     k_reg;
    logic [WORK_W-1:0] result_reg;

    logic              cfg_hit;
    logic [7:0]        len_new;
    logic [MW-1:0]     len_mod;
    logic [3:0]        n_cells;
    logic [8:0]        dshift;
    logic              dq;
    logic [4:0]        comb_sh;
    logic [WORK_W-1:0] comb_sum;
    logic [SUM_W-1:0]  sum_new;
    logic [CELL_W-1:0] w_mag;
    logic [PROD_W:0]   prod_rnd;
    logic [CELL_W-1:0] rnd_mag;
    logic [CELL_W-1:0] slope_k;
    logic [CELL_W-1:0] out_k;
    logic [CELL_W-1:0] out_new;
    logic [CELL_W-1:0] w_round;

    assign cfg_hit = cfg_we && (cfg_index <= REG_CELLS);
    assign len_new = (cfg_index == REG_LENGTH) ? cfg_data : length_reg;

    // reduce the delay length modulo the ring depth
    always_comb
    begin
        len_mod = {{(MW-8){1'b0}}, len_new};
        for (int j = 3; j >= 0; j--)
        begin
            if (len_mod >= MW'(HISTORY_DEPTH << j))
                len_mod = len_mod - MW'(HISTORY_DEPTH << j);
        end
    end

    assign n_cells = ({1'b0, cells_reg} > MAX_N) ? MAX_N : {1'b0, cells_reg};

    assign dshift = {rem_reg, dvd_reg[WORK_W-1]};
    assign dq = (dshift >= {1'b0, length_reg});

    assign comb_sh = (widen_reg == 5'd0) ? 5'd0 : widen_reg - 5'd1;
    assign comb_sum = WORK_W'(x_reg) + WORK_W'(rd_reg) + 32'd1;
    assign sum_new = sum_reg - SUM_W'(rd_reg) + SUM_W'(x_reg);

    assign slope_k = cell_slope_reg[k_reg];
    assign out_k = cell_out_reg[k_reg];
    assign out_new = out_k + slope_k;

    assign w_mag = w_reg[CELL_W-1] ? (CELL_W'(0) - w_reg) : w_reg;
    assign prod_rnd = {1'b0, prod_reg} + GAIN_ROUND;
    assign rnd_mag = prod_rnd[PROD_W-1:8];
    assign w_round = w_reg + HALF_COUNT;

    assign status.cfg_hit = cfg_hit;
    assign status.mode = mode_reg;
    assign status.lp_en = lp_en_reg;
    assign status.no_cells = (n_cells == 4'd0);
    assign status.last_cell = ({{(4-CW){1'b0}}, k_reg} + 4'd1 == n_cells);
    assign status.div_done = (dcnt_reg == 5'(DIV_STEPS - 1));
    assign status.clr_last = (clr_idx_reg == LAST_IDX);

    assign filtered = result_reg;

    // history ring memory
    always_ff @(posedge clk)
    begin
        if (op == OP_CLR)
            hist_mem[clr_idx_reg] <= '0;
        else if (op == OP_HWR)
            hist_mem[widx_reg] <= x_reg;
        if (op == OP_HRD)
            rd_reg <= hist_mem[ridx_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                x_reg <= sample;
                work_reg <= WORK_W'(sample);
            end
            OP_HWR:
            begin
                work_reg <= WORK_W'(x_reg) << widen_reg;
            end
            OP_NCALC:
            begin
                work_reg <= comb_sum << comb_sh;
            end
            OP_DLOAD:
            begin
                dvd_reg <= WORK_W'(sum_reg) << widen_reg;
                rem_reg <= 8'd0;
            end
            OP_DSTEP:
            begin
                rem_reg <= dq ? 8'(dshift - {1'b0, length_reg}) : dshift[7:0];
                dvd_reg <= {dvd_reg[WORK_W-2:0], dq};
                work_reg <= {dvd_reg[WORK_W-2:0], dq};
            end
            OP_LPSTART:
            begin
                w_reg <= {work_reg, {FRAC_W{1'b0}}};
            end
            OP_CA:
            begin
                w_reg <= w_reg - out_k + slope_k;
            end
            OP_MUL:
            begin
                neg_reg <= w_reg[CELL_W-1];
                prod_reg <= PROD_W'(w_mag) * PROD_W'(gain_reg);
            end
            OP_RND:
            begin
                w_reg <= neg_reg ? (CELL_W'(0) - rnd_mag) : rnd_mag;
            end
            OP_CD:
            begin
                w_reg <= w_reg - slope_k - slope_k;
            end
            OP_CH:
            begin
                w_reg <= out_new;
            end
            OP_ROUND:
            begin
                result_reg <= w_round[CELL_W-1:FRAC_W];
            end
            OP_BYPASS:
            begin
                result_reg <= work_reg;
            end
            default:
            begin
            end
        endcase
    end

    // config and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            length_reg <= LENGTH_RESET;
            widen_reg <= WIDEN_RESET;
            lp_en_reg <= LP_EN_RESET;
            gain_reg <= GAIN_RESET;
            cells_reg <= CELLS_RESET;
            widx_reg <= WIDX_RESET;
            ridx_reg <= '0;
            clr_idx_reg <= '0;
            sum_reg <= '0;
            dcnt_reg <= '0;
            k_reg <= '0;
            for (int j = 0; j < MAX_CELLS; j++)
            begin
                cell_out_reg[j] <= '0;
                cell_slope_reg[j] <= '0;
            end
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg <= cfg_data[1:0];
                REG_LENGTH: length_reg <= cfg_data;
                REG_WIDEN:  widen_reg <= cfg_data[4:0];
                REG_LP_EN:  lp_en_reg <= cfg_data[0];
                REG_GAIN:   gain_reg <= cfg_data;
                REG_CELLS:  cells_reg <= cfg_data[2:0];
                default:    mode_reg <= mode_reg;
            endcase
            widx_reg <= len_mod[IW-1:0];
            ridx_reg <= '0;
            clr_idx_reg <= '0;
            sum_reg <= '0;
            for (int j = 0; j < MAX_CELLS; j++)
            begin
                cell_out_reg[j] <= '0;
                cell_slope_reg[j] <= '0;
            end
        end
        else
        begin
            case (op)
                OP_CLR:
                begin
                    clr_idx_reg <= (clr_idx_reg == LAST_IDX) ? '0 : clr_idx_reg + IW'(1);
                end
                OP_HWR:
                begin
                    widx_reg <= (widx_reg == LAST_IDX) ? '0 : widx_reg + IW'(1);
                end
                OP_HRD:
                begin
                    ridx_reg <= (ridx_reg == LAST_IDX) ? '0 : ridx_reg + IW'(1);
                end
                OP_NCALC:
                begin
                    if (mode_reg == MODE_AVG)
                        sum_reg <= sum_new;
                end
                OP_DLOAD:
                begin
                    dcnt_reg <= '0;
                end
                OP_DSTEP:
                begin
                    dcnt_reg <= dcnt_reg + 5'd1;
                end
                OP_LPSTART:
                begin
                    k_reg <= '0;
                end
                OP_CG:
                begin
                    cell_slope_reg[k_reg] <= slope_k + w_reg;
                end
                OP_CH:
                begin
                    cell_out_reg[k_reg] <= out_new;
                    k_reg <= k_reg + CW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ design/weigh_notch_and_lowpass_filter.sv @@
// Top level: weighing sample filter with notch stage and two-pole cell cascade.
// Mode OFF skips the notch; widen, comb and averager (32-step divider) add steps in turn,
// then each active low-pass cell runs; one sample is processed at a time.
// A new request is taken only after the previous result is issued, which out_ready can hold.
// Reset (async, active low) and every register write clear all filter state and
// start a sweep of the history ring, during which no request is taken.
`timescale 1ns / 1ps

module weigh_notch_and_lowpass_filter
    import wnlf_pkg::*;
#(
    parameter int HISTORY_DEPTH = 256,
    parameter int MAX_CELLS = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WORK_W-1:0]     filtered,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_op_t     op;
    dp_status_t status;

    wnlf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .op        (op)
    );

    wnlf_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_CELLS     (MAX_CELLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .op        (op),
        .status    (status),
        .filtered  (filtered)
    );

endmodule
